@@ src/rcd_pkg.sv @@
// Package for the command deframer: widths, phase codes, byte codes and the
// result record. Used by resp_command_deframer; depends on nothing.
package rcd_pkg;

  localparam int MAX_ARGS = 1024;
  localparam int LEN_BITS = 32;

  localparam int ARG_W   = $clog2(MAX_ARGS + 1);
  localparam int ACC_W   = LEN_BITS + 4;
  localparam int IDX_W   = 10;
  localparam int TDATA_W = 24;
  localparam int TUSER_W = 3;

  localparam logic [3:0] PH_IDLE   = 4'd0;
  localparam logic [3:0] PH_INL    = 4'd1;
  localparam logic [3:0] PH_INL_CR = 4'd2;
  localparam logic [3:0] PH_CNT    = 4'd3;
  localparam logic [3:0] PH_CNT_LF = 4'd4;
  localparam logic [3:0] PH_DOL    = 4'd5;
  localparam logic [3:0] PH_LEN    = 4'd6;
  localparam logic [3:0] PH_LEN_LF = 4'd7;
  localparam logic [3:0] PH_BODY   = 4'd8;
  localparam logic [3:0] PH_TR1    = 4'd9;
  localparam logic [3:0] PH_TR2    = 4'd10;

  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;

  typedef struct packed {
    logic [7:0]       payload_byte;
    logic             has_payload;
    logic [IDX_W-1:0] arg_index;
    logic             element_end;
    logic             cmd_done;
    logic             protocol_error;
  } res_t;

endpackage

@@ src/resp_command_deframer.sv @@
// Command deframer: splits a client byte stream into command arguments,
// either from RESP arrays or from space separated inline lines.
// Depends on rcd_pkg.
//
// Usage:
//   in_*  : one stream byte per request, in_tdata[7:0].
//   out_* : zero or one result per input byte. out_tdata carries the
//           content byte and argument index, out_tuser the flags,
//           out_tlast marks the end of a command.
//   Each accepted byte updates the parse state and computes its result in
//   the same cycle; the result is registered in the output register, or in
//   the skid register on a stall. While the skid register is empty a new
//   byte is accepted every cycle, so throughput is one byte per cycle.
//   When the receiver stalls, one result waits in the output register and a
//   second one in a skid register; in_tready drops only while the skid
//   register is full, and no result is lost.
//   Malformed framing yields one result with protocol_error set; the parser
//   then returns to idle and the next byte starts a new command.
//   Reset (rst_n low, synchronous) empties both registers and returns the
//   parser to idle. No clearing pass is needed.
module resp_command_deframer (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [7:0]                  in_tdata,   // [7:0] data_byte
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [rcd_pkg::TDATA_W-1:0] out_tdata,  // [7:0] payload_byte, [17:8] arg_index, [23:18] zero
  output logic [rcd_pkg::TUSER_W-1:0] out_tuser,  // [0] has_payload, [1] element_end, [2] protocol_error
  output logic                        out_tlast   // cmd_done
);

  logic [3:0]                   phase_r, phase_nxt;
  logic [rcd_pkg::LEN_BITS-1:0] accum_r, accum_nxt;
  logic [rcd_pkg::ARG_W-1:0]    elems_r, elems_nxt;
  logic [rcd_pkg::LEN_BITS-1:0] bytes_r, bytes_nxt;
  logic [rcd_pkg::ARG_W-1:0]    arg_r, arg_nxt;
  logic                         tok_r, tok_nxt;

  rcd_pkg::res_t res;
  logic          res_vld;
  logic          acc;

  rcd_pkg::res_t out_r, skid_r;
  logic          out_vld_r, skid_vld_r;
  logic          pop;

  logic [7:0]                   b;
  logic                         is_digit;
  logic [rcd_pkg::ACC_W-1:0]    prod;
  logic                         dig_ok;
  logic [rcd_pkg::ARG_W-1:0]    arg_eff;
  logic                         tok_eff;
  logic [rcd_pkg::LEN_BITS-1:0] bytes_dec;

  assign b         = in_tdata;
  assign acc       = in_tvalid && in_tready;
  assign in_tready = !skid_vld_r;
  assign pop       = out_vld_r && out_tready;

  assign is_digit  = (b >= rcd_pkg::CH_ZERO) && (b <= rcd_pkg::CH_NINE);
  assign prod      = (rcd_pkg::ACC_W'(accum_r) << 3) + (rcd_pkg::ACC_W'(accum_r) << 1)
                   + rcd_pkg::ACC_W'(b - rcd_pkg::CH_ZERO);
  assign dig_ok    = is_digit && (prod[rcd_pkg::ACC_W-1:rcd_pkg::LEN_BITS] == '0);
  assign arg_eff   = (phase_r == rcd_pkg::PH_IDLE) ? '0 : arg_r;
  assign tok_eff   = (phase_r == rcd_pkg::PH_IDLE) ? 1'b0 : tok_r;
  assign bytes_dec = bytes_r - 1'b1;

  always_comb begin
    phase_nxt = phase_r;
    accum_nxt = accum_r;
    elems_nxt = elems_r;
    bytes_nxt = bytes_r;
    arg_nxt   = arg_r;
    tok_nxt   = tok_r;
    res       = '0;
    res_vld   = 1'b0;
    case (phase_r)
      rcd_pkg::PH_IDLE, rcd_pkg::PH_INL: begin
        if (phase_r == rcd_pkg::PH_IDLE) begin
          accum_nxt = '0;
          elems_nxt = '0;
          bytes_nxt = '0;
          arg_nxt   = '0;
          tok_nxt   = 1'b0;
          phase_nxt = rcd_pkg::PH_INL;
        end
        if ((phase_r == rcd_pkg::PH_IDLE) && (b == rcd_pkg::CH_STAR)) begin
          phase_nxt = rcd_pkg::PH_CNT;
        end else if (b == rcd_pkg::CH_SPACE) begin
          if (tok_eff) begin
            tok_nxt         = 1'b0;
            res_vld         = 1'b1;
            res.arg_index   = rcd_pkg::IDX_W'(arg_eff);
            res.element_end = 1'b1;
            arg_nxt         = arg_eff + 1'b1;
          end
        end else if (b == rcd_pkg::CH_CR) begin
          phase_nxt = rcd_pkg::PH_INL_CR;
        end else if (!tok_eff && (arg_eff >= rcd_pkg::ARG_W'(rcd_pkg::MAX_ARGS))) begin
          phase_nxt = rcd_pkg::PH_IDLE;
          res_vld   = 1'b1;
          res.protocol_error = 1'b1;
        end else begin
          tok_nxt          = 1'b1;
          res_vld          = 1'b1;
          res.payload_byte = b;
          res.has_payload  = 1'b1;
          res.arg_index    = rcd_pkg::IDX_W'(arg_eff);
        end
      end
      rcd_pkg::PH_INL_CR: begin
        phase_nxt = rcd_pkg::PH_IDLE;
        if (b != rcd_pkg::CH_LF) begin
          res_vld = 1'b1;
          res.protocol_error = 1'b1;
        end else if (tok_r) begin
          res_vld         = 1'b1;
          res.arg_index   = rcd_pkg::IDX_W'(arg_r);
          res.element_end = 1'b1;
          res.cmd_done    = 1'b1;
        end else if (arg_r != '0) begin
          res_vld         = 1'b1;
          res.arg_index   = rcd_pkg::IDX_W'(arg_r - 1'b1);
          res.cmd_done    = 1'b1;
        end
      end
      rcd_pkg::PH_CNT: begin
        if (b == rcd_pkg::CH_CR) begin
          if (!tok_r || ({1'b0, accum_r} > (rcd_pkg::LEN_BITS+1)'(rcd_pkg::MAX_ARGS))) begin
            phase_nxt = rcd_pkg::PH_IDLE;
            res_vld   = 1'b1;
            res.protocol_error = 1'b1;
          end else begin
            elems_nxt = rcd_pkg::ARG_W'(accum_r);
            phase_nxt = rcd_pkg::PH_CNT_LF;
          end
        end else if (dig_ok) begin
          accum_nxt = prod[rcd_pkg::LEN_BITS-1:0];
          tok_nxt   = 1'b1;
        end else begin
          phase_nxt = rcd_pkg::PH_IDLE;
          res_vld   = 1'b1;
          res.protocol_error = 1'b1;
        end
      end
      rcd_pkg::PH_CNT_LF: begin
        if (b != rcd_pkg::CH_LF) begin
          phase_nxt = rcd_pkg::PH_IDLE;
          res_vld   = 1'b1;
          res.protocol_error = 1'b1;
        end else if (elems_r == '0) begin
          phase_nxt = rcd_pkg::PH_IDLE;
        end else begin
          phase_nxt = rcd_pkg::PH_DOL;
        end
      end
      rcd_pkg::PH_DOL: begin
        if (b != rcd_pkg::CH_DOLLAR) begin
          phase_nxt = rcd_pkg::PH_IDLE;
          res_vld   = 1'b1;
          res.protocol_error = 1'b1;
        end else begin
          accum_nxt = '0;
          tok_nxt   = 1'b0;
          phase_nxt = rcd_pkg::PH_LEN;
        end
      end
      rcd_pkg::PH_LEN: begin
        if (b == rcd_pkg::CH_CR) begin
          if (!tok_r) begin
            phase_nxt = rcd_pkg::PH_IDLE;
            res_vld   = 1'b1;
            res.protocol_error = 1'b1;
          end else begin
            bytes_nxt = accum_r;
            phase_nxt = rcd_pkg::PH_LEN_LF;
          end
        end else if (dig_ok) begin
          accum_nxt = prod[rcd_pkg::LEN_BITS-1:0];
          tok_nxt   = 1'b1;
        end else begin
          phase_nxt = rcd_pkg::PH_IDLE;
          res_vld   = 1'b1;
          res.protocol_error = 1'b1;
        end
      end
      rcd_pkg::PH_LEN_LF: begin
        if (b != rcd_pkg::CH_LF) begin
          phase_nxt = rcd_pkg::PH_IDLE;
          res_vld   = 1'b1;
          res.protocol_error = 1'b1;
        end else begin
          phase_nxt = (bytes_r != '0) ? rcd_pkg::PH_BODY : rcd_pkg::PH_TR1;
        end
      end
      rcd_pkg::PH_BODY: begin
        bytes_nxt = bytes_dec;
        if (bytes_dec == '0) begin
          phase_nxt = rcd_pkg::PH_TR1;
        end
        res_vld          = 1'b1;
        res.payload_byte = b;
        res.has_payload  = 1'b1;
        res.arg_index    = rcd_pkg::IDX_W'(arg_r);
      end
      rcd_pkg::PH_TR1: begin
        phase_nxt = rcd_pkg::PH_TR2;
      end
      rcd_pkg::PH_TR2: begin
        res_vld         = 1'b1;
        res.arg_index   = rcd_pkg::IDX_W'(arg_r);
        res.element_end = 1'b1;
        if (elems_r <= rcd_pkg::ARG_W'(1)) begin
          res.cmd_done = 1'b1;
          phase_nxt    = rcd_pkg::PH_IDLE;
        end else begin
          elems_nxt = elems_r - 1'b1;
          arg_nxt   = arg_r + 1'b1;
          phase_nxt = rcd_pkg::PH_DOL;
        end
      end
      default: begin
        phase_nxt = rcd_pkg::PH_IDLE;
        res_vld   = 1'b1;
        res.protocol_error = 1'b1;
      end
    endcase
    // errors and finished commands leave the counters cleared
    if (phase_nxt == rcd_pkg::PH_IDLE) begin
      accum_nxt = '0;
      elems_nxt = '0;
      bytes_nxt = '0;
      arg_nxt   = '0;
      tok_nxt   = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= rcd_pkg::PH_IDLE;
      accum_r <= '0;
      elems_r <= '0;
      bytes_r <= '0;
      arg_r   <= '0;
      tok_r   <= 1'b0;
    end else if (acc) begin
      phase_r <= phase_nxt;
      accum_r <= accum_nxt;
      elems_r <= elems_nxt;
      bytes_r <= bytes_nxt;
      arg_r   <= arg_nxt;
      tok_r   <= tok_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r  <= 1'b0;
      skid_vld_r <= 1'b0;
    end else if (skid_vld_r) begin
      if (pop) begin
        out_r      <= skid_r;
        skid_vld_r <= 1'b0;
      end
    end else if (!out_vld_r || pop) begin
      out_vld_r <= acc && res_vld;
      out_r     <= res;
    end else if (acc && res_vld) begin
      skid_r     <= res;
      skid_vld_r <= 1'b1;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {6'd0, out_r.arg_index, out_r.payload_byte};
  assign out_tuser  = {out_r.protocol_error, out_r.element_end, out_r.has_payload};
  assign out_tlast  = out_r.cmd_done;

  a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_vld_r |-> out_vld_r)
    else $error("skid register full while output register empty");

  a_err_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && out_r.protocol_error) |->
      (out_r.arg_index == '0 && !out_r.has_payload && !out_r.element_end
       && !out_r.cmd_done && out_r.payload_byte == '0))
    else $error("error result carries other fields");

  a_pay_not_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r |-> !(out_r.has_payload && out_r.element_end))
    else $error("content byte and element end in one result");

  a_body_count: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == rcd_pkg::PH_BODY) |-> (bytes_r != '0))
    else $error("body phase with no bytes left");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (skid_vld_r && !out_tready) |=> (skid_vld_r && $stable(skid_r)))
    else $error("skid register changed while output stalled");

endmodule
